// File: sv/hcih4_pkg.sv
// Shared types and constants for the H4 receive deframer.
`timescale 1ns / 1ps

package hcih4_pkg;

	localparam int LEN_W = 17;

	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_CMD  = 2'd1;
	localparam logic [1:0] KIND_ACL  = 2'd2;
	localparam logic [1:0] KIND_EVT  = 2'd3;

	localparam logic [7:0] H4_TYPE_CMD = 8'h01;
	localparam logic [7:0] H4_TYPE_ACL = 8'h02;
	localparam logic [7:0] H4_TYPE_EVT = 8'h04;

	localparam logic [LEN_W-1:0] CMD_HDR_LEN = 17'd3;
	localparam logic [LEN_W-1:0] ACL_HDR_LEN = 17'd4;
	localparam logic [LEN_W-1:0] EVT_HDR_LEN = 17'd2;

	typedef struct packed {
		logic [7:0]       data;
		logic [1:0]       kind;
		logic [LEN_W-1:0] index;
		logic             is_type;
		logic             last;
		logic             err;
	} res_t;

endpackage

// File: sv/hcih4_parse.sv
// Packet state tracking and per-byte classification.
`timescale 1ns / 1ps

module hcih4_parse
	import hcih4_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] rx_byte,
	output res_t       res
);

	logic [1:0]       kind_q;
	logic [LEN_W-1:0] count_q;
	logic [LEN_W-1:0] exp_q;

	logic [1:0]       kind_d;
	logic [LEN_W-1:0] count_d;
	logic [LEN_W-1:0] exp_d;
	logic [LEN_W-1:0] count_inc;
	logic [LEN_W-1:0] exp_new;
	logic [LEN_W-1:0] hdr;
	logic [LEN_W-1:0] byte_ext;

	assign byte_ext  = {{(LEN_W-8){1'b0}}, rx_byte};
	assign count_inc = count_q + {{(LEN_W-1){1'b0}}, 1'b1};

	always_comb begin
		res.data    = rx_byte;
		res.kind    = KIND_NONE;
		res.index   = '0;
		res.is_type = 1'b0;
		res.last    = 1'b0;
		res.err     = 1'b0;
		kind_d      = kind_q;
		count_d     = count_q;
		exp_d       = exp_q;
		exp_new     = exp_q;
		hdr         = ACL_HDR_LEN;

		if (kind_q == KIND_NONE) begin
			unique case (rx_byte)
				H4_TYPE_CMD: kind_d = KIND_CMD;
				H4_TYPE_ACL: kind_d = KIND_ACL;
				H4_TYPE_EVT: kind_d = KIND_EVT;
				default:     res.err = 1'b1;
			endcase
			if (!res.err) begin
				res.is_type = 1'b1;
				res.kind    = kind_d;
				count_d     = '0;
				exp_d       = '0;
			end
		end else begin
			res.kind  = kind_q;
			res.index = count_q;
			unique case (kind_q)
				KIND_CMD: begin
					hdr = CMD_HDR_LEN;
					if (count_q == 17'd2)
						exp_new = byte_ext + CMD_HDR_LEN;
				end
				KIND_EVT: begin
					hdr = EVT_HDR_LEN;
					if (count_q == 17'd1)
						exp_new = byte_ext + EVT_HDR_LEN;
				end
				default: begin
					hdr = ACL_HDR_LEN;
					if (count_q == 17'd2)
						exp_new = byte_ext;
					else if (count_q == 17'd3)
						exp_new = {1'b0, rx_byte, exp_q[7:0]} + ACL_HDR_LEN;
				end
			endcase
			count_d = count_inc;
			exp_d   = exp_new;
			if (count_inc >= hdr && count_inc == exp_new) begin
				res.last = 1'b1;
				kind_d   = KIND_NONE;
				count_d  = '0;
				exp_d    = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q  <= KIND_NONE;
			count_q <= '0;
			exp_q   <= '0;
		end else if (step) begin
			kind_q  <= kind_d;
			count_q <= count_d;
			exp_q   <= exp_d;
		end
	end

	a_err_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.err |=> kind_q == KIND_NONE)
		else $error("rejected type byte left idle");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.last |=> kind_q == KIND_NONE && count_q == '0 && exp_q == '0)
		else $error("state not cleared after last byte");

	a_idle_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		kind_q == KIND_NONE |-> count_q == '0)
		else $error("byte count nonzero while idle");

endmodule

// File: sv/hcih4_outreg.sv
// Result register with downstream valid/stall handshake.
`timescale 1ns / 1ps

module hcih4_outreg
	import hcih4_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  res_t res_in,
	input  logic out_stall,
	output logic advance,
	output logic out_valid,
	output res_t res_s2
);

	logic valid_s2;

	assign advance   = !valid_s2 || !out_stall;
	assign out_valid = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && load)
			res_s2 <= res_in;
	end

endmodule

// File: sv/hci_uart_h4_rx_deframer.sv
// Top level of the H4 receive deframer: input register, parser, result register.
//
// channel  direction  handshake             payload
// in       sink       in_valid / in_stall   rx_byte
// out      source     out_valid / out_stall byte_out, packet_kind, body_index,
//                                           is_type_byte, last_of_packet, type_error
//
// One request per cycle sustained while out_stall is low; each byte passes through
// the input register, then the result register, and gives one result.
// Packet state advances as a byte moves from the input to the result register.
// Reset clears packet state and both valid flags.
// out_stall holds a full result register and, once the input register is full,
// raises in_stall in the same cycle.
`timescale 1ns / 1ps

module hci_uart_h4_rx_deframer
	import hcih4_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [7:0]       rx_byte,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [7:0]       byte_out,
	output logic [1:0]       packet_kind,
	output logic [LEN_W-1:0] body_index,
	output logic             is_type_byte,
	output logic             last_of_packet,
	output logic             type_error
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;
	logic       step;
	res_t       res;
	res_t       res_s2;

	assign step     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid)
			byte_s1 <= rx_byte;
	end

	hcih4_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_byte (byte_s1),
		.res     (res)
	);

	hcih4_outreg u_outreg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (valid_s1),
		.res_in    (res),
		.out_stall (out_stall),
		.advance   (advance),
		.out_valid (out_valid),
		.res_s2    (res_s2)
	);

	assign byte_out       = res_s2.data;
	assign packet_kind    = res_s2.kind;
	assign body_index     = res_s2.index;
	assign is_type_byte   = res_s2.is_type;
	assign last_of_packet = res_s2.last;
	assign type_error     = res_s2.err;

endmodule
